FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

FILE: rtl/core/kbd_pkg.sv
// Types, constants and key tables for the keyboard scancode key buffer.
package kbd_pkg;

    localparam int KEY_COUNT = 90;
    localparam int KEY_IDX_W = 7;

    localparam logic [6:0] CODE_ALT    = 7'h38;
    localparam logic [6:0] CODE_CTRL   = 7'h1D;
    localparam logic [6:0] CODE_LSHIFT = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT = 7'h36;
    localparam logic [6:0] CODE_CAPS   = 7'h3A;

    localparam logic [7:0] HIGH_LIMIT = 8'h85;

    localparam logic [7:0] SVC_READ  = 8'd0;
    localparam logic [7:0] SVC_PEEK  = 8'd1;
    localparam logic [7:0] SVC_SHIFT = 8'd2;

    localparam logic REG_BUFFER_ENTRIES = 1'b0;

    typedef enum logic [2:0] {
        TAB_PLAIN,
        TAB_SHIFT,
        TAB_CAPS,
        TAB_CTRL,
        TAB_ALT
    } table_sel_t;

    typedef struct packed {
        logic load_item;
        logic mark_key;
        logic push_key;
        logic fetch_word;
        logic reply;
    } cmd_t;

    typedef struct packed {
        logic make_code;
    } status_t;

    typedef logic [7:0] key_rom_t [0:KEY_COUNT-1];

    localparam key_rom_t ROM_PLAIN = '{
        8'd0, 8'd27, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56,
        8'd57, 8'd48, 8'd45, 8'd61, 8'd8, 8'd9,
        8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121, 8'd117, 8'd105, 8'd111,
        8'd112, 8'd91, 8'd93, 8'd13, 8'd0,
        8'd97, 8'd115, 8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108,
        8'd59, 8'd39, 8'd96, 8'd0, 8'd92,
        8'd122, 8'd120, 8'd99, 8'd118, 8'd98, 8'd110, 8'd109, 8'd44, 8'd46,
        8'd47, 8'd0, 8'd42, 8'd0, 8'd32, 8'd0,
        8'd187, 8'd188, 8'd189, 8'd190, 8'd191, 8'd192, 8'd193, 8'd194, 8'd195,
        8'd196, 8'd0, 8'd0, 8'd199, 8'd200,
        8'd201, 8'd45, 8'd203, 8'd204, 8'd205, 8'd43, 8'd207, 8'd208, 8'd209,
        8'd210, 8'd211, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0
    };

    localparam key_rom_t ROM_SHIFT = '{
        8'd0, 8'd27, 8'd33, 8'd64, 8'd35, 8'd36, 8'd37, 8'd94, 8'd38, 8'd42,
        8'd40, 8'd41, 8'd95, 8'd43, 8'd8, 8'd143,
        8'd81, 8'd87, 8'd69, 8'd82, 8'd84, 8'd89, 8'd85, 8'd73, 8'd79, 8'd80,
        8'd123, 8'd125, 8'd13, 8'd0, 8'd65, 8'd83,
        8'd68, 8'd70, 8'd71, 8'd72, 8'd74, 8'd75, 8'd76, 8'd58, 8'd34, 8'd126,
        8'd0, 8'd124, 8'd90, 8'd88, 8'd67, 8'd86,
        8'd66, 8'd78, 8'd77, 8'd60, 8'd62, 8'd63, 8'd0, 8'd0, 8'd0, 8'd32,
        8'd0, 8'd212, 8'd213, 8'd214, 8'd215, 8'd216,
        8'd217, 8'd218, 8'd219, 8'd220, 8'd221, 8'd0, 8'd0, 8'd199, 8'd200,
        8'd201, 8'd45, 8'd203, 8'd204, 8'd205,
        8'd43, 8'd207, 8'd208, 8'd209, 8'd210, 8'd211,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam key_rom_t ROM_CAPS = '{
        8'd0, 8'd27, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56,
        8'd57, 8'd48, 8'd45, 8'd61, 8'd8, 8'd143,
        8'd81, 8'd87, 8'd69, 8'd82, 8'd84, 8'd89, 8'd85, 8'd73, 8'd79, 8'd80,
        8'd91, 8'd93, 8'd13, 8'd0, 8'd65, 8'd83,
        8'd68, 8'd70, 8'd71, 8'd72, 8'd74, 8'd75, 8'd76, 8'd59, 8'd39, 8'd96,
        8'd0, 8'd92, 8'd90, 8'd88, 8'd67, 8'd86,
        8'd66, 8'd78, 8'd77, 8'd44, 8'd46, 8'd47, 8'd0, 8'd0, 8'd0, 8'd32,
        8'd0, 8'd212, 8'd213, 8'd214, 8'd215, 8'd216,
        8'd217, 8'd218, 8'd219, 8'd220, 8'd221, 8'd0, 8'd0, 8'd199, 8'd200,
        8'd201, 8'd45, 8'd203, 8'd204, 8'd205,
        8'd43, 8'd207, 8'd208, 8'd209, 8'd210, 8'd211,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam key_rom_t ROM_CTRL = '{
        8'd0, 8'd27, 8'd33, 8'd0, 8'd35, 8'd36, 8'd37, 8'd30, 8'd38, 8'd42,
        8'd40, 8'd41, 8'd31, 8'd43, 8'd127, 8'd9,
        8'd17, 8'd23, 8'd5, 8'd18, 8'd20, 8'd25, 8'd21, 8'd9, 8'd15, 8'd16,
        8'd27, 8'd29, 8'd13, 8'd0, 8'd1, 8'd19,
        8'd4, 8'd6, 8'd7, 8'd8, 8'd10, 8'd11, 8'd12, 8'd59, 8'd44, 8'd96,
        8'd0, 8'd28, 8'd26, 8'd24, 8'd3, 8'd22,
        8'd2, 8'd14, 8'd178, 8'd60, 8'd62, 8'd63, 8'd0, 8'd0, 8'd0, 8'd32,
        8'd0, 8'd222, 8'd223, 8'd224, 8'd225, 8'd226,
        8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd0, 8'd0, 8'd199, 8'd200,
        8'd201, 8'd45, 8'd203, 8'd204, 8'd205,
        8'd43, 8'd207, 8'd208, 8'd209, 8'd210, 8'd211,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam key_rom_t ROM_ALT = '{
        8'd0, 8'd27, 8'd33, 8'd64, 8'd35, 8'd36, 8'd37, 8'd94, 8'd38, 8'd42,
        8'd40, 8'd41, 8'd95, 8'd43, 8'd8, 8'd143,
        8'd144, 8'd145, 8'd146, 8'd147, 8'd148, 8'd149, 8'd150, 8'd151, 8'd152,
        8'd153, 8'd123, 8'd125, 8'd13, 8'd0,
        8'd158, 8'd159, 8'd160, 8'd161, 8'd162, 8'd163, 8'd164, 8'd165, 8'd166,
        8'd58, 8'd34, 8'd126, 8'd0, 8'd124,
        8'd172, 8'd173, 8'd174, 8'd175, 8'd176, 8'd177, 8'd178, 8'd60, 8'd62,
        8'd63, 8'd0, 8'd0, 8'd0, 8'd32, 8'd0,
        8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255, 8'd128,
        8'd129, 8'd0, 8'd0, 8'd199, 8'd200,
        8'd201, 8'd45, 8'd203, 8'd204, 8'd205, 8'd43, 8'd207, 8'd208, 8'd209,
        8'd210, 8'd211, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0
    };

    // Looks a key up in the selected table and forms the 16-bit key word.
    // Extended values land in the upper byte; most of them lose bit 7.
    function automatic logic [15:0] translate_key(input table_sel_t sel,
                                                  input logic [KEY_IDX_W-1:0] idx);
        logic [7:0]  v;
        logic [15:0] w;
        case (sel)
            TAB_ALT:   v = ROM_ALT[idx];
            TAB_CTRL:  v = ROM_CTRL[idx];
            TAB_SHIFT: v = ROM_SHIFT[idx];
            TAB_CAPS:  v = ROM_CAPS[idx];
            default:   v = ROM_PLAIN[idx];
        endcase
        if (v[7]) begin
            if (v >= HIGH_LIMIT) begin
                v[7] = 1'b0;
            end
            w = {v, 8'h00};
        end else begin
            w = {8'h00, v};
        end
        return w;
    endfunction

endpackage

FILE: rtl/core/kbd_ctrl.sv
// Sequencer that steps each transaction through the key buffer datapath.
module kbd_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            op,
    input  kbd_pkg::status_t stat,
    output kbd_pkg::cmd_t   cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [2:0] {
        IDLE,
        KEY_MARK,
        KEY_PUSH,
        SVC_FETCH,
        SVC_REPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (start) begin
                    state_next = op ? SVC_FETCH : KEY_MARK;
                end
            end
            KEY_MARK:
            begin
                state_next = stat.make_code ? KEY_PUSH : IDLE;
            end
            KEY_PUSH:
            begin
                state_next = IDLE;
            end
            SVC_FETCH:
            begin
                state_next = SVC_REPLY;
            end
            SVC_REPLY:
            begin
                state_next = IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd.load_item  = (state_reg == IDLE) && start;
        cmd.mark_key   = (state_reg == KEY_MARK);
        cmd.push_key   = (state_reg == KEY_PUSH);
        cmd.fetch_word = (state_reg == SVC_FETCH);
        cmd.reply      = (state_reg == SVC_REPLY);
    end

    assign busy = (state_reg != IDLE);
    assign done = done_reg;

endmodule

FILE: rtl/core/kbd_dpath.sv
// Datapath: pressed-key map, key translation, key ring and service results.
module kbd_dpath
#(
    parameter int RING_DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  kbd_pkg::cmd_t    cmd,
    output kbd_pkg::status_t stat,
    input  logic [7:0]       scan_code,
    input  logic [7:0]       service,
    input  logic [6:0]       buffer_entries,
    output logic [15:0]      key_word,
    output logic             zero_flag
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);

    logic [7:0]                      code_reg;
    logic [7:0]                      svc_reg;
    logic [kbd_pkg::KEY_COUNT-1:0]   pressed_reg;
    logic [15:0]                     ring_mem [0:RING_DEPTH-1];
    logic [15:0]                     rd_data_reg;
    logic [SLOT_W-1:0]               wr_slot_reg;
    logic [SLOT_W-1:0]               rd_slot_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [15:0]                     key_word_reg;
    logic                            zero_flag_reg;

    logic [kbd_pkg::KEY_IDX_W-1:0]   key_idx;
    kbd_pkg::table_sel_t             tab_sel;
    logic [15:0]                     push_word;
    logic [CNT_W-1:0]                ring_size;
    logic [CNT_W-1:0]                wr_inc;
    logic [CNT_W-1:0]                rd_inc;
    logic [SLOT_W-1:0]               wr_slot_next;
    logic [SLOT_W-1:0]               rd_slot_next;
    logic [CNT_W:0]                  count_inc;
    logic                            shift_held;
    logic [15:0]                     key_word_next;
    logic                            zero_flag_next;

    assign stat.make_code = ~code_reg[7];

    // Release codes use the low seven bits; codes past the table map to key 0.
    assign key_idx = (code_reg[6:0] >= 7'(kbd_pkg::KEY_COUNT)) ? '0 : code_reg[6:0];

    always_comb
    begin
        if (pressed_reg[kbd_pkg::CODE_ALT]) begin
            tab_sel = kbd_pkg::TAB_ALT;
        end else if (pressed_reg[kbd_pkg::CODE_CTRL]) begin
            tab_sel = kbd_pkg::TAB_CTRL;
        end else if (pressed_reg[kbd_pkg::CODE_LSHIFT] || pressed_reg[kbd_pkg::CODE_RSHIFT]) begin
            tab_sel = kbd_pkg::TAB_SHIFT;
        end else if (pressed_reg[kbd_pkg::CODE_CAPS]) begin
            tab_sel = kbd_pkg::TAB_CAPS;
        end else begin
            tab_sel = kbd_pkg::TAB_PLAIN;
        end
    end

    assign push_word = kbd_pkg::translate_key(tab_sel, key_idx);

    always_comb
    begin
        if (buffer_entries == 7'd0) begin
            ring_size = CNT_W'(1);
        end else if (buffer_entries > 7'(RING_DEPTH)) begin
            ring_size = CNT_W'(RING_DEPTH);
        end else begin
            ring_size = buffer_entries[CNT_W-1:0];
        end
    end

    assign wr_inc       = CNT_W'(wr_slot_reg) + CNT_W'(1);
    assign rd_inc       = CNT_W'(rd_slot_reg) + CNT_W'(1);
    assign wr_slot_next = (wr_inc >= ring_size) ? '0 : wr_inc[SLOT_W-1:0];
    assign rd_slot_next = (rd_inc >= ring_size) ? '0 : rd_inc[SLOT_W-1:0];
    assign count_inc    = {1'b0, count_reg} + (CNT_W+1)'(1);

    assign shift_held = pressed_reg[kbd_pkg::CODE_LSHIFT] | pressed_reg[kbd_pkg::CODE_RSHIFT];

    always_comb
    begin
        key_word_next  = 16'h0000;
        zero_flag_next = 1'b1;
        case (svc_reg)
            kbd_pkg::SVC_READ:
            begin
                if (count_reg != '0) begin
                    key_word_next  = rd_data_reg;
                    zero_flag_next = (count_reg == CNT_W'(1));
                end
            end
            kbd_pkg::SVC_PEEK:
            begin
                if (count_reg != '0) begin
                    key_word_next  = rd_data_reg;
                    zero_flag_next = 1'b0;
                end
            end
            kbd_pkg::SVC_SHIFT:
            begin
                key_word_next  = {15'h0000, shift_held};
                zero_flag_next = ~shift_held;
            end
            default:
            begin
                key_word_next  = 16'h0000;
                zero_flag_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item) begin
            code_reg <= scan_code;
            svc_reg  <= service;
        end
        if (cmd.reply) begin
            key_word_reg  <= key_word_next;
            zero_flag_reg <= zero_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_key) begin
            ring_mem[wr_slot_reg] <= push_word;
        end
        if (cmd.fetch_word) begin
            rd_data_reg <= ring_mem[rd_slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pressed_reg <= '0;
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            count_reg   <= '0;
        end else begin
            if (cmd.mark_key) begin
                pressed_reg[key_idx] <= ~code_reg[7];
            end
            if (cmd.push_key) begin
                wr_slot_reg <= wr_slot_next;
                // A full ring drops its oldest word.
                if (count_inc > {1'b0, ring_size}) begin
                    count_reg   <= ring_size;
                    rd_slot_reg <= wr_slot_next;
                end else begin
                    count_reg <= count_inc[CNT_W-1:0];
                end
            end
            if (cmd.reply && (svc_reg == kbd_pkg::SVC_READ) && (count_reg != '0)) begin
                rd_slot_reg <= rd_slot_next;
                count_reg   <= count_reg - CNT_W'(1);
            end
        end
    end

    assign key_word  = key_word_reg;
    assign zero_flag = zero_flag_reg;

endmodule

FILE: rtl/core/keyboard_scancode_key_buffer.sv
// Top level of the keyboard scancode key buffer with its register port.
//
//   Channel   Signals                                  Direction
//   command   start, busy, op, scan_code, service      in (busy out)
//   result    done, key_word, zero_flag                out
//   register  psel, penable, pwrite, paddr, pwdata,    in (prdata, pready out)
//             prdata, pready
//
// A make code runs the controller's mark and push states, a break code only mark,
// and a service request fetch, with its registered ring read, followed by reply.
// The result of a service request appears with done in the first cycle in which
// busy is low again and stays for exactly one cycle; the receiver cannot stall it.
// Reset clears the pressed-key map, the ring slots and count, and sets the
// ring size to one word.
`include "assert_macros.svh"

module keyboard_scancode_key_buffer
#(
    parameter int RING_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [7:0]  scan_code,
    input  logic [7:0]  service,
    output logic        done,
    output logic [15:0] key_word,
    output logic        zero_flag
);

    logic [6:0]       entries_reg;
    logic             cfg_write;
    kbd_pkg::cmd_t    cmd;
    kbd_pkg::status_t stat;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= 7'd1;
        end
        else if (cfg_write && (paddr[2] == kbd_pkg::REG_BUFFER_ENTRIES))
        begin
            entries_reg <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == kbd_pkg::REG_BUFFER_ENTRIES) ? {25'd0, entries_reg} : 32'd0;

    kbd_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    kbd_dpath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .scan_code      (scan_code),
        .service        (service),
        .buffer_entries (entries_reg),
        .key_word       (key_word),
        .zero_flag      (zero_flag)
    );

    // An accepted transaction always keeps the block busy in the next cycle.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // A result strobe lasts a single cycle.
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    // The result is shown only once the sequencer has returned to idle.
    `ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)

endmodule
